// ===== src/spcs_pkg.sv =====
// Shared types and constants for the sample phase calibration search unit.
// Used by spcs_ctrl, spcs_dp and the top level; no dependencies.
package spcs_pkg;

   localparam int MAX_PHASES_DEF  = 16;
   localparam int METRIC_BITS_DEF = 32;
   localparam int PHASE_BITS      = 4;
   localparam int NARROW_PHASES   = 8;
   localparam int WIDE_PHASES     = 16;
   localparam int STEP_BITS       = 5;

   typedef logic [PHASE_BITS-1:0] phase_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      rearm;
      logic      load;
      phase_type wr_idx;
      logic      rd;
      phase_type rd_idx;
      logic      eval;
      logic      first;
      phase_type center;
      logic      emit;
   } cmd_type;

endpackage

// ===== src/sample_phase_calibration_search_unit.sv =====
// Flow: after the Nth metric beat is taken (N is 8 or 16), busy stays high
//   through the walk and emit, and rsp_strobe rises as busy falls.
// Throughput: one metric per cycle while loading; no metrics are taken
//   during the serial walk over the metric store and the emit.
// Results cannot be stalled. Synchronous active-high reset clears control,
//   the running minimum (to all ones) and the phase range (8 phases).
module sample_phase_calibration_search_unit #(
   parameter int MAX_PHASES  = spcs_pkg::MAX_PHASES_DEF,
   parameter int METRIC_BITS = spcs_pkg::METRIC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [METRIC_BITS-1:0] req_error_metric,
   output logic                   rsp_strobe,
   output spcs_pkg::phase_type    rsp_best_phase,
   output logic [METRIC_BITS-1:0] rsp_least_metric,
   output logic [METRIC_BITS+1:0] rsp_best_window_sum,
   input  logic                   csr_we,
   input  logic                   csr_wdata
);
   import spcs_pkg::*;

   cmd_type cmd;

   spcs_ctrl #(
      .MAX_PHASES(MAX_PHASES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   spcs_dp #(
      .MAX_PHASES (MAX_PHASES),
      .METRIC_BITS(METRIC_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .metric              (req_error_metric),
      .rsp_strobe          (rsp_strobe),
      .rsp_best_phase      (rsp_best_phase),
      .rsp_least_metric    (rsp_least_metric),
      .rsp_best_window_sum (rsp_best_window_sum)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_ends_walk: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("walk ended without a result");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({2'b00, rsp_least_metric} + {2'b00, rsp_least_metric}
                      + {2'b00, rsp_least_metric} <= rsp_best_window_sum))
      else $error("window sum below three times the minimum");

endmodule

// ===== src/spcs_ctrl.sv =====
// Controller for the phase search: load counter, walk sequencer and the
// phase range register. Depends on spcs_pkg.
module spcs_ctrl #(
   parameter int MAX_PHASES = spcs_pkg::MAX_PHASES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output spcs_pkg::cmd_type cmd
);
   import spcs_pkg::*;

   localparam logic [STEP_BITS-1:0] NARROW_N =
      STEP_BITS'((NARROW_PHASES < MAX_PHASES) ? NARROW_PHASES : MAX_PHASES);
   localparam logic [STEP_BITS-1:0] WIDE_N =
      STEP_BITS'((WIDE_PHASES < MAX_PHASES) ? WIDE_PHASES : MAX_PHASES);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] count_ff, count_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 wide_ff, wide_in;
   logic [STEP_BITS-1:0] phases;
   logic [STEP_BITS-1:0] last;
   logic [STEP_BITS-1:0] rd_end;
   logic [STEP_BITS-1:0] walk_end;

   assign phases   = wide_ff ? WIDE_N : NARROW_N;
   assign last     = phases - STEP_BITS'(1);
   assign rd_end   = phases + STEP_BITS'(1);
   assign walk_end = phases + STEP_BITS'(4);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && count_ff == last) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (step_ff == walk_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      wide_in  = wide_ff;
      step_in  = '0;
      if (csr_we) begin
         wide_in  = csr_wdata;
         count_in = '0;
      end else if (state_ff == ST_LOAD && start) begin
         count_in = (count_ff == last) ? '0 : count_ff + STEP_BITS'(1);
      end
      if (state_ff == ST_WALK) step_in = step_ff + STEP_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         step_ff  <= '0;
         wide_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         wide_ff  <= wide_in;
      end
   end

   // Walk reads entries n-1, 0, 1 .. n-1, 0 so every window wraps.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy       = 1'b0;
            cmd.rearm  = csr_we;
            cmd.load   = start;
            cmd.wr_idx = PHASE_BITS'(count_ff);
         end
         ST_WALK: begin
            cmd.rd = (step_ff <= rd_end);
            if (step_ff == '0) begin
               cmd.rd_idx = PHASE_BITS'(last);
            end else if (step_ff == rd_end) begin
               cmd.rd_idx = '0;
            end else begin
               cmd.rd_idx = PHASE_BITS'(step_ff - STEP_BITS'(1));
            end
            cmd.eval   = (step_ff >= STEP_BITS'(2)) && (step_ff <= rd_end);
            cmd.first  = (step_ff == STEP_BITS'(2));
            cmd.center = PHASE_BITS'(step_ff - STEP_BITS'(2));
         end
         ST_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.rearm = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/spcs_dp.sv =====
// Datapath for the phase search: metric store, running minimum, window
// pipeline, best-phase tracking and result registers. Depends on spcs_pkg.
module spcs_dp #(
   parameter int MAX_PHASES  = spcs_pkg::MAX_PHASES_DEF,
   parameter int METRIC_BITS = spcs_pkg::METRIC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spcs_pkg::cmd_type         cmd,
   input  logic [METRIC_BITS-1:0]    metric,
   output logic                      rsp_strobe,
   output spcs_pkg::phase_type       rsp_best_phase,
   output logic [METRIC_BITS-1:0]    rsp_least_metric,
   output logic [METRIC_BITS+1:0]    rsp_best_window_sum
);
   import spcs_pkg::*;

   localparam int AW    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int SUM_W = METRIC_BITS + 2;

   logic [METRIC_BITS-1:0] store [MAX_PHASES];
   logic [METRIC_BITS-1:0] rd_q_ff;
   logic [METRIC_BITS-1:0] min_ff;
   logic [METRIC_BITS-1:0] win0_ff, win1_ff, win2_ff;

   logic                   shift_ff, eval1_ff, first1_ff;
   phase_type              center1_ff;
   logic                   eval2_ff, first2_ff;
   phase_type              center2_ff;
   logic                   eval3_ff, first3_ff, hit_ff;
   phase_type              center3_ff;
   logic [SUM_W-1:0]       sum_ff;

   logic                   found_ff;
   logic                   found_cur;
   phase_type              best_idx_ff;
   logic [SUM_W-1:0]       best_sum_ff;

   logic                   strobe_ff;
   phase_type              rsp_phase_ff;
   logic [METRIC_BITS-1:0] rsp_least_ff;
   logic [SUM_W-1:0]       rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) store[AW'(cmd.wr_idx)] <= metric;
      if (cmd.rd) rd_q_ff <= store[AW'(cmd.rd_idx)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
      end else if (cmd.rearm) begin
         min_ff <= '1;
      end else if (cmd.load && metric < min_ff) begin
         min_ff <= metric;
      end
   end

   // Pipeline flags: read data, window, sum/compare, best update.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         eval1_ff <= 1'b0;
         eval2_ff <= 1'b0;
         eval3_ff <= 1'b0;
      end else begin
         shift_ff <= cmd.rd;
         eval1_ff <= cmd.eval;
         eval2_ff <= eval1_ff;
         eval3_ff <= eval2_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff  <= cmd.first;
      center1_ff <= cmd.center;
      first2_ff  <= first1_ff;
      center2_ff <= center1_ff;
      first3_ff  <= first2_ff;
      center3_ff <= center2_ff;
      if (shift_ff) begin
         win0_ff <= win1_ff;
         win1_ff <= win2_ff;
         win2_ff <= rd_q_ff;
      end
      sum_ff <= {2'b00, win0_ff} + {2'b00, win1_ff} + {2'b00, win2_ff};
      hit_ff <= (win1_ff == min_ff);
   end

   assign found_cur = first3_ff ? 1'b0 : found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (eval3_ff) begin
         if (hit_ff && (!found_cur || sum_ff < best_sum_ff)) begin
            found_ff <= 1'b1;
         end else begin
            found_ff <= found_cur;
         end
      end
   end

   // Keep the lowest phase on a tie: after the first minimum-metric center, replace only on a strictly smaller sum.
   always_ff @(posedge clock) begin
      if (eval3_ff && hit_ff && (!found_cur || sum_ff < best_sum_ff)) begin
         best_idx_ff <= center3_ff;
         best_sum_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_phase_ff <= best_idx_ff;
         rsp_least_ff <= min_ff;
         rsp_sum_ff   <= best_sum_ff;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_best_phase      = rsp_phase_ff;
   assign rsp_least_metric    = rsp_least_ff;
   assign rsp_best_window_sum = rsp_sum_ff;

endmodule
